// ===== sv/tekd_pkg.sv =====
// types and constants for the terminal escape key decoder
// no dependencies; imported by tekd_decode and terminal_escape_key_decoder
`default_nettype none

package tekd_pkg;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_ESC  = 4'd1,
    PH_SS3  = 4'd2,
    PH_CSI  = 4'd3,
    PH_CSI1 = 4'd4,
    PH_CSI2 = 4'd5,
    PH_CSI3 = 4'd6,
    PH_PAGE = 4'd7,
    PH_LINF = 4'd8,
    PH_SKIP = 4'd9
  } phase_e;

  localparam logic [7:0] BYTE_BS     = 8'd8;
  localparam logic [7:0] BYTE_ESC    = 8'd27;
  localparam logic [7:0] BYTE_SEMI   = 8'd59;
  localparam logic [7:0] BYTE_SS3    = 8'd79;
  localparam logic [7:0] BYTE_CSI    = 8'd91;
  localparam logic [7:0] BYTE_CARET  = 8'd94;
  localparam logic [7:0] BYTE_TILDE  = 8'd126;

  localparam logic [8:0] CODE_DEL    = 9'd127;
  localparam logic [8:0] CODE_ESC    = 9'd27;
  localparam logic [8:0] CODE_UP     = 9'd152;
  localparam logic [8:0] CODE_PGUP   = 9'd156;
  localparam logic [8:0] CODE_PGDN   = 9'd157;
  localparam logic [8:0] CODE_HOME   = 9'd158;
  localparam logic [8:0] CODE_END    = 9'd159;
  localparam logic [8:0] CODE_INS    = 9'd160;
  localparam logic [8:0] CODE_DELK   = 9'd161;
  localparam logic [8:0] CODE_CTRL   = 9'd256;

  typedef struct packed {
    phase_e     phase;
    logic [8:0] pending;
    logic [1:0] skip;
  } dec_state_t;

  typedef struct packed {
    logic       emit;
    logic [8:0] code;
    logic       stop;
  } dec_result_t;

endpackage

`default_nettype wire

// ===== sv/tekd_decode.sv =====
// next-state and key code decode for one received byte
// depends on tekd_pkg
`default_nettype none

module tekd_decode import tekd_pkg::*; (
  input  dec_state_t  state_i,
  input  logic [7:0]  key_byte_i,
  input  logic        timeout_i,
  input  logic        xterm_i,
  output dec_state_t  state_o,
  output dec_result_t result_o
);

  logic [8:0] b9;
  logic [8:0] c1;

  assign b9 = {1'b0, key_byte_i};
  assign c1 = b9 + 9'd79;

  always_comb begin
    state_o  = state_i;
    result_o = '{emit: 1'b0, code: 9'd0, stop: 1'b0};

    if (timeout_i) begin
      if (state_i.phase == PH_ESC) begin
        state_o.phase = PH_IDLE;
        result_o      = '{emit: 1'b1, code: CODE_ESC, stop: 1'b1};
      end
    end else begin
      case (state_i.phase)
        PH_ESC: begin
          if (key_byte_i == BYTE_CSI) begin
            state_o.phase = PH_CSI;
          end else if (key_byte_i == BYTE_SS3) begin
            state_o.phase = PH_SS3;
          end else begin
            state_o.phase = PH_IDLE;
            result_o.emit = 1'b1;
            if ((key_byte_i >= 8'd32 && key_byte_i <= 8'd57) ||
                (key_byte_i >= 8'd97 && key_byte_i <= 8'd122)) begin
              result_o.code = b9 + 9'd128;
            end else if ((key_byte_i >= 8'd65 && key_byte_i <= 8'd78) ||
                         (key_byte_i >= 8'd80 && key_byte_i <= 8'd90)) begin
              result_o.code = b9 + 9'd160;
            end else begin
              result_o.code = CODE_ESC;
              result_o.stop = 1'b1;
            end
          end
        end
        PH_SS3: begin
          state_o.phase = PH_IDLE;
          result_o.emit = 1'b1;
          result_o.code = (key_byte_i >= 8'd80 && key_byte_i <= 8'd84) ? b9 + 9'd49 : b9;
        end
        PH_CSI: begin
          case (key_byte_i)
            8'd49: state_o.phase = PH_CSI1;
            8'd50: state_o.phase = PH_CSI2;
            8'd51: state_o.phase = PH_CSI3;
            8'd52: begin
              state_o.phase   = PH_SKIP;
              state_o.pending = CODE_END;
              state_o.skip    = 2'd1;
            end
            8'd53: begin
              state_o.phase   = PH_PAGE;
              state_o.pending = CODE_PGUP;
            end
            8'd54: begin
              state_o.phase   = PH_PAGE;
              state_o.pending = CODE_PGDN;
            end
            8'd65, 8'd66, 8'd67, 8'd68: begin
              state_o.phase = PH_IDLE;
              result_o.emit = 1'b1;
              result_o.code = CODE_UP + (b9 - 9'd65);
            end
            BYTE_CSI: begin
              if (!xterm_i) begin
                state_o.phase = PH_LINF;
              end else begin
                state_o.phase = PH_IDLE;
                result_o.emit = 1'b1;
                result_o.code = b9;
              end
            end
            default: begin
              state_o.phase = PH_IDLE;
              result_o.emit = 1'b1;
              result_o.code = b9;
            end
          endcase
        end
        PH_CSI1: begin
          if (key_byte_i == BYTE_TILDE) begin
            state_o.phase = PH_IDLE;
            result_o.emit = 1'b1;
            result_o.code = CODE_HOME;
          end else begin
            state_o.phase   = PH_SKIP;
            state_o.pending = (xterm_i && c1 <= 9'd132) ? c1 + 9'd1 : c1;
            state_o.skip    = 2'd1;
          end
        end
        PH_CSI2: begin
          if (key_byte_i == BYTE_TILDE) begin
            state_o.phase = PH_IDLE;
            result_o.emit = 1'b1;
            result_o.code = CODE_INS;
          end else begin
            state_o.phase   = PH_SKIP;
            state_o.pending = b9 + 9'd89;
            state_o.skip    = 2'd1;
          end
        end
        PH_CSI3: begin
          if (key_byte_i == BYTE_TILDE) begin
            state_o.phase = PH_IDLE;
            result_o.emit = 1'b1;
            result_o.code = CODE_DELK;
          end else begin
            state_o.phase   = PH_SKIP;
            state_o.pending = b9 + 9'd98;
            state_o.skip    = 2'd1;
          end
        end
        PH_PAGE: begin
          if (xterm_i && key_byte_i == BYTE_SEMI) begin
            state_o.phase   = PH_SKIP;
            state_o.pending = state_i.pending + CODE_CTRL;
            state_o.skip    = 2'd2;
          end else begin
            state_o.phase = PH_IDLE;
            result_o.emit = 1'b1;
            result_o.code = (!xterm_i && key_byte_i == BYTE_CARET) ?
                            state_i.pending + CODE_CTRL : state_i.pending;
          end
        end
        PH_LINF: begin
          state_o.phase = PH_IDLE;
          result_o.emit = 1'b1;
          result_o.code = (key_byte_i >= 8'd65 && key_byte_i <= 8'd69) ? b9 + 9'd64 : b9;
        end
        PH_SKIP: begin
          if (state_i.skip > 2'd1) begin
            state_o.skip = state_i.skip - 2'd1;
          end else begin
            state_o.skip  = 2'd0;
            state_o.phase = PH_IDLE;
            result_o.emit = 1'b1;
            result_o.code = state_i.pending;
          end
        end
        default: begin
          if (key_byte_i == BYTE_ESC) begin
            state_o.phase = PH_ESC;
          end else begin
            state_o.phase = PH_IDLE;
            result_o.emit = 1'b1;
            result_o.code = (key_byte_i == BYTE_BS) ? CODE_DEL : b9;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/terminal_escape_key_decoder.sv =====
// terminal escape key decoder top level: decode state, mode register, result register
// depends on tekd_pkg and tekd_decode
// output: a key code is registered and appears in the cycle after the transfer of the byte that ends its sequence
// throughput: one byte per cycle; input stalls only while a held result is stalled
// reset: idle phase, pending code and skip count zero, linux console mode, no result held
`default_nettype none

module terminal_escape_key_decoder import tekd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] key_byte_i,
  input  logic       timeout_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [8:0] key_code_o,
  output logic       stop_tx_o
);

  logic        xterm_q;
  dec_state_t  state_q;
  dec_state_t  state_d;
  dec_result_t res_d;
  logic        out_valid_q;
  logic [8:0]  code_q;
  logic        stop_q;
  logic        in_xfer;
  logic        out_xfer;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign out_xfer   = out_valid_q & ~out_stall_i;

  tekd_decode u_decode (
    .state_i    (state_q),
    .key_byte_i (key_byte_i),
    .timeout_i  (timeout_i),
    .xterm_i    (xterm_q),
    .state_o    (state_d),
    .result_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xterm_q     <= 1'b0;
      state_q     <= '{phase: PH_IDLE, pending: 9'd0, skip: 2'd0};
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        xterm_q <= cfg_wdata_i;
      end
      if (in_xfer) begin
        state_q     <= state_d;
        out_valid_q <= res_d.emit;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && res_d.emit) begin
      code_q <= res_d.code;
      stop_q <= res_d.stop;
    end
  end

  assign out_valid_o = out_valid_q;
  assign key_code_o  = code_q;
  assign stop_tx_o   = stop_q;

endmodule

`default_nettype wire
